>>> hw/rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared constants, codes and the CRC-8 step for the packet deframer.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT        = 8'h00;
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h00;
  localparam logic [BYTE_W-1:0] MAX_LEN_RST      = 8'd60;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSTART  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CRCBAD   = 2'd3;

  // Register indexes (paddr[2])
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_LEN      = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // CRC-8, MSB first, one byte per call
  function automatic byte_t crc8_update(input byte_t acc, input byte_t b);
    byte_t v;
    v = acc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/packet_receive_deframer_crc8.sv
// ----------------------------------------------------------------------------
// packet_receive_deframer_crc8
// Parses start/type/length/payload/CRC-8 frames from a byte stream and
// emits payload bytes and end-of-frame or error status transactions.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_ready, in_rx_byte          | in
//  result   | out_valid, out_ready, out_payload_byte, | out
//           | out_frame_type, out_frame_len,          |
//           | out_status, out_frame_end               |
//  config   | psel, penable, pwrite, paddr, pwdata,   | APB
//           | prdata, pready                          |
//
// One byte per cycle while in_ready is high: parse state and the result
// register update on acceptance; the result is visible in the cycle after.
// The CRC step is an unrolled eight-bit update between state registers.
// in_ready is high when the result register is empty or being drained.
// Synchronous active-low reset puts the parser in start-byte hunt and
// loads register defaults (start marker 0, max length 60).
// ----------------------------------------------------------------------------
module packet_receive_deframer_crc8 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prd_pkg::BYTE_W-1:0]    out_payload_byte,
  output logic [prd_pkg::BYTE_W-1:0]    out_frame_type,
  output logic [prd_pkg::BYTE_W-1:0]    out_frame_len,
  output logic [prd_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prd_pkg::APB_AW-1:0]    paddr,
  input  logic [prd_pkg::APB_DW-1:0]    pwdata,
  output logic [prd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import prd_pkg::*;

  localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CRC     = 3'd4;

  byte_t start_marker_r, max_len_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  byte_t held_type_r, held_type_nxt;
  byte_t held_len_r, held_len_nxt;
  byte_t remain_r, remain_nxt;
  byte_t crc_r, crc_nxt;

  logic                out_valid_r;
  byte_t               out_payload_r, out_payload_nxt;
  byte_t               out_type_r, out_type_nxt;
  byte_t               out_len_r, out_len_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_end_r, out_end_nxt;
  logic                emit;
  logic                in_fire;
  logic                cfg_wr;
  byte_t               remain_dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    unique case (paddr[2])
      REG_START_MARKER: prdata = {{(APB_DW-BYTE_W){1'b0}}, start_marker_r};
      REG_MAX_LEN:      prdata = {{(APB_DW-BYTE_W){1'b0}}, max_len_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      max_len_r      <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_MARKER) begin
        start_marker_r <= pwdata[BYTE_W-1:0];
      end else begin
        max_len_r <= pwdata[BYTE_W-1:0];
      end
    end
  end

  // Parser next state and result for the byte on the input
  always_comb begin
    phase_nxt       = phase_r;
    held_type_nxt   = held_type_r;
    held_len_nxt    = held_len_r;
    remain_nxt      = remain_r;
    crc_nxt         = crc_r;
    emit            = 1'b0;
    out_payload_nxt = '0;
    out_type_nxt    = held_type_r;
    out_len_nxt     = held_len_r;
    out_status_nxt  = ST_OK;
    out_end_nxt     = 1'b1;
    unique case (phase_r)
      PH_TYPE: begin
        held_type_nxt = in_rx_byte;
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        held_len_nxt = in_rx_byte;
        if (in_rx_byte > max_len_r) begin
          phase_nxt      = PH_HUNT;
          emit           = 1'b1;
          out_len_nxt    = in_rx_byte;
          out_status_nxt = ST_OVERFLOW;
        end else begin
          crc_nxt    = CRC_INIT;
          remain_nxt = in_rx_byte;
          phase_nxt  = (in_rx_byte == '0) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_nxt    = crc8_update(crc_r, in_rx_byte);
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_CRC;
        end
        emit            = 1'b1;
        out_payload_nxt = in_rx_byte;
        out_end_nxt     = 1'b0;
      end
      PH_CRC: begin
        phase_nxt      = PH_HUNT;
        emit           = 1'b1;
        out_status_nxt = (in_rx_byte == crc_r) ? ST_OK : ST_CRCBAD;
      end
      default: begin
        // hunt; unused codes land here too
        phase_nxt = PH_HUNT;
        if (in_rx_byte == start_marker_r) begin
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_TYPE;
        end else begin
          emit           = 1'b1;
          out_type_nxt   = '0;
          out_len_nxt    = '0;
          out_status_nxt = ST_NOSTART;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      held_type_r <= '0;
      held_len_r  <= '0;
      remain_r    <= '0;
      crc_r       <= CRC_INIT;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      held_type_r <= held_type_nxt;
      held_len_r  <= held_len_nxt;
      remain_r    <= remain_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result register only when a transaction produces one
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_payload_r <= out_payload_nxt;
      out_type_r    <= out_type_nxt;
      out_len_r     <= out_len_nxt;
      out_status_r  <= out_status_nxt;
      out_end_r     <= out_end_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_r;
  assign out_frame_type   = out_type_r;
  assign out_frame_len    = out_len_r;
  assign out_status       = out_status_r;
  assign out_frame_end    = out_end_r;

endmodule
